// File: hw/rtl/mec_pkg.sv
// Shared constants for the Mandelbrot escape counter.
package mec_pkg;

    // Parameter defaults.
    localparam int DEF_IMAGE_WIDTH  = 1024;
    localparam int DEF_IMAGE_HEIGHT = 1024;
    localparam int DEF_PALETTE_SIZE = 512;

    // Field and datapath widths.
    localparam int OFS_W      = 10;
    localparam int CNT_W      = 16;
    localparam int N_W        = CNT_W + 1;
    localparam int PIDX_W     = 9;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int Z_W        = 34;
    localparam int FRAC_BITS  = 28;
    localparam int STEP_W     = 31;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 32;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_RE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_IM  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_STEP = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_LIM  = 3'd3;

    // Register reset values.
    localparam logic [STEP_W-1:0] PIXEL_STEP_RST  = 31'd1048576;
    localparam logic [CNT_W-1:0]  COUNT_LIMIT_RST = 16'd16416;

    // Escape radius squared (4.0) in Q.56, and the |z| bound of 2.0 in Q.28.
    localparam logic signed [PROD_W-1:0] MAG_LIMIT = 64'sh0400_0000_0000_0000;
    localparam logic signed [Z_W-1:0]    Z_HI      = 34'sh0_2000_0000;
    localparam logic signed [Z_W-1:0]    Z_LO      = -34'sh0_2000_0000;

endpackage

// File: hw/rtl/mec_mul.sv
// Shared signed multiplier with a registered product.
module mec_mul
(
    input  logic                                clk,
    input  logic signed [mec_pkg::MUL_W-1:0]    a,
    input  logic signed [mec_pkg::MUL_W-1:0]    b,
    output logic signed [mec_pkg::PROD_W-1:0]   p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

// File: hw/rtl/mandelbrot_escape_count.sv
// Mandelbrot escape counter: maps a pixel offset to c and iterates z = z*z + c.
// The number of iterations is escape_count / 2; one shared 32x32 multiplier does three
// products per iteration, and the last iteration skips the update step.
// A new pixel is accepted only when the sequencer is idle; a held result word stalls
// the next one.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, clears the output
// valid and sets the configuration registers to their reset values.
module mandelbrot_escape_count
#(
    parameter int IMAGE_WIDTH  = mec_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = mec_pkg::DEF_IMAGE_HEIGHT,
    parameter int PALETTE_SIZE = mec_pkg::DEF_PALETTE_SIZE
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [mec_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mec_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // offset_x [9:0], offset_y [19:10], zero [23:20]
    input  logic [mec_pkg::IN_W-1:0]            s_tdata,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // escape_count [15:0], escaped [16], palette_index [25:17], zero [31:26]
    output logic [mec_pkg::OUT_W-1:0]           m_tdata
);

    localparam int PAL_W = $clog2(PALETTE_SIZE) + 1;

    localparam logic signed [15:0] X_LO = 16'(-(IMAGE_WIDTH / 2));
    localparam logic signed [15:0] X_HI = 16'(IMAGE_WIDTH / 2 - 1);
    localparam logic signed [15:0] Y_LO = 16'(-(IMAGE_HEIGHT / 2));
    localparam logic signed [15:0] Y_HI = 16'(IMAGE_HEIGHT / 2 - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CX   = 4'd1;
    localparam logic [3:0] S_CY   = 4'd2;
    localparam logic [3:0] S_CI   = 4'd3;
    localparam logic [3:0] S_SQR  = 4'd4;
    localparam logic [3:0] S_SQI  = 4'd5;
    localparam logic [3:0] S_XY   = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    function automatic logic signed [31:0] sat_c(input logic signed [41:0] s);
        logic signed [31:0] r;
        if (s > 42'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (s < -42'sh0_8000_0000)
            r = -32'sh8000_0000;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic [PAL_W-1:0] pal_step(input logic [PAL_W-1:0] v);
        logic [PAL_W-1:0] s;
        s = v + PAL_W'(2);
        if (s >= PAL_W'(PALETTE_SIZE))
            s = s - PAL_W'(PALETTE_SIZE);
        return s;
    endfunction

    function automatic logic signed [mec_pkg::OFS_W-1:0] clamp_ofs(
        input logic signed [mec_pkg::OFS_W-1:0] v,
        input logic signed [15:0]               lo,
        input logic signed [15:0]               hi
    );
        logic signed [15:0] w;
        w = 16'(v);
        if (w < lo)
            w = lo;
        else if (w > hi)
            w = hi;
        return w[mec_pkg::OFS_W-1:0];
    endfunction

    // Configuration registers.
    logic signed [31:0]                 center_re_reg;
    logic signed [31:0]                 center_im_reg;
    logic [mec_pkg::STEP_W-1:0]         step_reg;
    logic [mec_pkg::CNT_W-1:0]          limit_reg;

    // Control state.
    logic [3:0]                         state_reg, state_next;
    logic                               out_valid_reg, out_valid_next;

    // Datapath.
    logic signed [mec_pkg::OFS_W-1:0]   ox_reg, oy_reg;
    logic signed [31:0]                 cr_reg, ci_reg;
    logic signed [mec_pkg::Z_W-1:0]     zr_reg, zi_reg;
    logic signed [mec_pkg::PROD_W-1:0]  acc_reg, diff_reg;
    logic                               bound_reg;
    logic [mec_pkg::N_W-1:0]            n_reg;
    logic [PAL_W-1:0]                   pal_reg;
    logic [mec_pkg::CNT_W-1:0]          out_cnt_reg;
    logic                               out_esc_reg;
    logic [mec_pkg::PIDX_W-1:0]         out_pal_reg;

    logic signed [mec_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [mec_pkg::PROD_W-1:0]  prod;
    logic signed [mec_pkg::PROD_W-1:0]  mag;
    logic signed [mec_pkg::PROD_W-1:0]  re_sh, im_sh;
    logic signed [41:0]                 c_sum_re, c_sum_im;
    logic                               escape_now, stop_now, load_out, in_acc;
    logic [31:0]                        pal_ext;
    logic                               esc_final;

    mec_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign in_acc     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign mag        = acc_reg + prod;
    assign escape_now = bound_reg || (mag > mec_pkg::MAG_LIMIT);
    assign stop_now   = escape_now || (n_reg >= mec_pkg::N_W'(limit_reg));
    assign load_out   = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign re_sh      = diff_reg >>> mec_pkg::FRAC_BITS;
    assign im_sh      = prod >>> (mec_pkg::FRAC_BITS - 1);
    assign c_sum_re   = 42'(center_re_reg) + signed'(prod[41:0]);
    assign c_sum_im   = 42'(center_im_reg) + signed'(prod[41:0]);
    assign pal_ext    = 32'(pal_reg);
    assign esc_final  = (n_reg < mec_pkg::N_W'(limit_reg));

    // Multiplier operand selection by sequencer step.
    always_comb
    begin
        mul_a = zr_reg[mec_pkg::MUL_W-1:0];
        mul_b = zr_reg[mec_pkg::MUL_W-1:0];
        case (state_reg)
            S_CX:
            begin
                mul_a = mec_pkg::MUL_W'(ox_reg);
                mul_b = signed'({1'b0, step_reg});
            end
            S_CY:
            begin
                mul_a = mec_pkg::MUL_W'(oy_reg);
                mul_b = signed'({1'b0, step_reg});
            end
            S_SQI:
            begin
                mul_a = zi_reg[mec_pkg::MUL_W-1:0];
                mul_b = zi_reg[mec_pkg::MUL_W-1:0];
            end
            S_XY:
            begin
                mul_a = zr_reg[mec_pkg::MUL_W-1:0];
                mul_b = zi_reg[mec_pkg::MUL_W-1:0];
            end
            default:
            begin
                mul_a = zr_reg[mec_pkg::MUL_W-1:0];
                mul_b = zr_reg[mec_pkg::MUL_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_CX;
            S_CX:    state_next = S_CY;
            S_CY:    state_next = S_CI;
            S_CI:    state_next = S_SQR;
            S_SQR:   state_next = S_SQI;
            S_SQI:   state_next = S_XY;
            S_XY:    state_next = stop_now ? S_DONE : S_UPD;
            S_UPD:   state_next = S_SQR;
            S_DONE:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            center_re_reg <= '0;
            center_im_reg <= '0;
            step_reg      <= mec_pkg::PIXEL_STEP_RST;
            limit_reg     <= mec_pkg::COUNT_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    mec_pkg::CFG_CENTER_RE:  center_re_reg <= signed'(cfg_wdata);
                    mec_pkg::CFG_CENTER_IM:  center_im_reg <= signed'(cfg_wdata);
                    mec_pkg::CFG_PIXEL_STEP: step_reg <= cfg_wdata[mec_pkg::STEP_W-1:0];
                    mec_pkg::CFG_COUNT_LIM:  limit_reg <= cfg_wdata[mec_pkg::CNT_W-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ox_reg <= clamp_ofs(signed'(s_tdata[9:0]), X_LO, X_HI);
                oy_reg <= clamp_ofs(signed'(s_tdata[19:10]), Y_LO, Y_HI);
            end
            S_CY:
            begin
                cr_reg <= sat_c(c_sum_re);
            end
            S_CI:
            begin
                // The first iteration from z = 0 simply gives z = c.
                ci_reg  <= sat_c(c_sum_im);
                zr_reg  <= mec_pkg::Z_W'(cr_reg);
                zi_reg  <= mec_pkg::Z_W'(sat_c(c_sum_im));
                n_reg   <= mec_pkg::N_W'(2);
                pal_reg <= pal_step('0);
            end
            S_SQR:
            begin
                bound_reg <= (zr_reg > mec_pkg::Z_HI) || (zr_reg < mec_pkg::Z_LO) ||
                             (zi_reg > mec_pkg::Z_HI) || (zi_reg < mec_pkg::Z_LO);
            end
            S_SQI:
            begin
                acc_reg <= prod;
            end
            S_XY:
            begin
                diff_reg <= acc_reg - prod;
            end
            S_UPD:
            begin
                // Products are floored to Q.28 by the arithmetic shifts.
                zr_reg  <= signed'(re_sh[mec_pkg::Z_W-1:0]) + mec_pkg::Z_W'(cr_reg);
                zi_reg  <= signed'(im_sh[mec_pkg::Z_W-1:0]) + mec_pkg::Z_W'(ci_reg);
                n_reg   <= n_reg + mec_pkg::N_W'(2);
                pal_reg <= pal_step(pal_reg);
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_cnt_reg <= n_reg[mec_pkg::CNT_W] ? '1 : n_reg[mec_pkg::CNT_W-1:0];
            out_esc_reg <= esc_final;
            out_pal_reg <= esc_final ? pal_ext[mec_pkg::PIDX_W-1:0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_pal_reg, out_esc_reg, out_cnt_reg};

endmodule

// File: tb/tb_mandelbrot_escape_count.sv
// Testbench for mandelbrot_escape_count: checks each result word, predicted or given in the plan.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_count;

    localparam int          IMG_W         = mec_pkg::DEF_IMAGE_WIDTH;
    localparam int          IMG_H         = mec_pkg::DEF_IMAGE_HEIGHT;
    localparam int          PALETTE       = mec_pkg::DEF_PALETTE_SIZE;
    localparam longint      Q28_TWO       = longint'(2) << mec_pkg::FRAC_BITS;
    localparam longint      RADIUS_SQ     = longint'(4) << (2 * mec_pkg::FRAC_BITS);
    localparam longint      Q_MIN         = -(longint'(1) << 31);
    localparam longint      Q_MAX         = (longint'(1) << 31) - 1;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          END_CYCLES    = 20;
    localparam int unsigned CYCLE_LIMIT   = 4000000;
    localparam int          MAX_REPORTS   = 10;

    // Same layout as m_tdata[25:0].
    typedef struct packed {
        logic [mec_pkg::PIDX_W-1:0] pidx;
        logic                       escaped;
        logic [mec_pkg::CNT_W-1:0]  count;
    } pixel_result_t;

    typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        logic [mec_pkg::CFG_ADDR_W-1:0] idx;
        logic [mec_pkg::CFG_DATA_W-1:0] value;
        logic [mec_pkg::OFS_W-1:0]      ox;
        logic [mec_pkg::OFS_W-1:0]      oy;
        bit                             typed;
        pixel_result_t                  res;
    } dir_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [mec_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [mec_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [mec_pkg::IN_W-1:0]       s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [mec_pkg::OUT_W-1:0]      m_tdata;

    // Shadow copy of the view registers.
    longint      view_re    = 0;
    longint      view_im    = 0;
    longint      view_step  = longint'(mec_pkg::PIXEL_STEP_RST);
    int unsigned view_limit = mec_pkg::COUNT_LIMIT_RST;

    pixel_result_t pending_pixels[$];
    int            mismatch_count   = 0;
    int            sender_idle_pct  = 0;
    int            recv_stall_pct   = 0;
    int unsigned   cycle_count      = 0;

    mandelbrot_escape_count u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    always @(negedge clk)
    begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic bit beyond_radius(input longint re, input longint im);
        if (re > Q28_TWO || re < -Q28_TWO || im > Q28_TWO || im < -Q28_TWO)
            return 1'b1;
        return (re * re + im * im) > RADIUS_SQ;
    endfunction

    function automatic pixel_result_t escape_time(input logic [mec_pkg::OFS_W-1:0] ofs_x,
                                                  input logic [mec_pkg::OFS_W-1:0] ofs_y);
        longint        ox;
        longint        oy;
        longint        cr;
        longint        ci;
        longint        zr;
        longint        zi;
        longint        nr;
        longint        ni;
        int unsigned   n;
        int unsigned   pal_n;
        bit            done;
        pixel_result_t r;
        ox = clamp(longint'($signed(ofs_x)), -(IMG_W / 2), IMG_W / 2 - 1);
        oy = clamp(longint'($signed(ofs_y)), -(IMG_H / 2), IMG_H / 2 - 1);
        cr = clamp(view_re + ox * view_step, Q_MIN, Q_MAX);
        ci = clamp(view_im + oy * view_step, Q_MIN, Q_MAX);
        zr = 0;
        zi = 0;
        n = 0;
        done = 1'b0;
        // The count moves in half steps: one for the test before the update, one after.
        do
        begin
            n++;
            if (beyond_radius(zr, zi))
                done = 1'b1;
            else
            begin
                n++;
                nr = ((zr * zr - zi * zi) >>> mec_pkg::FRAC_BITS) + cr;
                ni = ((2 * zr * zi) >>> mec_pkg::FRAC_BITS) + ci;
                zr = nr;
                zi = ni;
                done = beyond_radius(zr, zi);
            end
        end while (!done && n < view_limit);
        pal_n = n % PALETTE;
        r.count = (n > 65535) ? 16'hFFFF : n[mec_pkg::CNT_W-1:0];
        r.escaped = (n < view_limit);
        r.pidx = r.escaped ? pal_n[mec_pkg::PIDX_W-1:0] : '0;
        return r;
    endfunction

    always @(posedge clk)
    begin : check_results
        pixel_result_t got;
        pixel_result_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(pixel_result_t)-1:0];
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result word: count %0d escaped %0d index %0d",
                             got.count, got.escaped, got.pidx);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: expected count %0d escaped %0d index %0d,",
                                  " got %0d %0d %0d"},
                                 want.count, want.escaped, want.pidx,
                                 got.count, got.escaped, got.pidx);
                end
            end
        end
    end

    task automatic write_reg(input logic [mec_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [mec_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mec_pkg::CFG_CENTER_RE:  view_re = longint'($signed(value));
            mec_pkg::CFG_CENTER_IM:  view_im = longint'($signed(value));
            mec_pkg::CFG_PIXEL_STEP: view_step = longint'(value[mec_pkg::STEP_W-1:0]);
            mec_pkg::CFG_COUNT_LIM:  view_limit = value[mec_pkg::CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Holds the sender off until every pending pixel has come back, plus some slack.
    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_pixels.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic send_pixel(input logic [mec_pkg::OFS_W-1:0] ox,
                              input logic [mec_pkg::OFS_W-1:0] oy,
                              input bit typed, input pixel_result_t typed_res);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(mec_pkg::IN_W - 2 * mec_pkg::OFS_W){1'b0}}, oy, ox};
        do
            @(posedge clk);
        while (!s_tready);
        pending_pixels.push_back(typed ? typed_res : escape_time(ox, oy));
        @(negedge clk);
    endtask

    task automatic random_view();
        logic [mec_pkg::CFG_DATA_W-1:0] re;
        logic [mec_pkg::CFG_DATA_W-1:0] im;
        logic [mec_pkg::CFG_DATA_W-1:0] step;
        int unsigned                    lim;
        int unsigned                    sh;
        if ($urandom_range(7) == 0)
        begin
            // Anywhere in the Q4.28 range; bit 31 of the step word must be dropped.
            re   = $urandom;
            im   = $urandom;
            step = $urandom;
            lim  = $urandom_range(2, 3000);
        end
        else
        begin
            // Views around the set, from deep zoom to wider than the whole set.
            re   = $urandom_range(671088640) - 536870912;
            im   = $urandom_range(671088640) - 335544320;
            sh   = $urandom_range(4, 22);
            step = $urandom_range((1 << sh), (2 << sh) - 1);
            lim  = ($urandom_range(3) == 0) ? $urandom_range(400, 2000) : $urandom_range(2, 300);
        end
        write_reg(mec_pkg::CFG_CENTER_RE, re);
        write_reg(mec_pkg::CFG_CENTER_IM, im);
        write_reg(mec_pkg::CFG_PIXEL_STEP, step);
        write_reg(mec_pkg::CFG_COUNT_LIM, lim);
        if ($urandom_range(2) == 0)
            write_reg(mec_pkg::CFG_COUNT_LIM + 3'($urandom_range(1, 4)), $urandom);
    endtask

    function automatic dir_row_t reg_row(input logic [mec_pkg::CFG_ADDR_W-1:0] idx,
                                         input logic [mec_pkg::CFG_DATA_W-1:0] value);
        dir_row_t r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.value = value;
        r.ox    = '0;
        r.oy    = '0;
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic dir_row_t pixel_row(input int ox, input int oy);
        dir_row_t r;
        r.kind  = ROW_PIXEL;
        r.idx   = '0;
        r.value = '0;
        r.ox    = ox[mec_pkg::OFS_W-1:0];
        r.oy    = oy[mec_pkg::OFS_W-1:0];
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic dir_row_t known_row(input int ox, input int oy, input int cnt,
                                           input bit esc, input int pidx);
        dir_row_t r;
        r = pixel_row(ox, oy);
        r.typed       = 1'b1;
        r.res.count   = cnt[mec_pkg::CNT_W-1:0];
        r.res.escaped = esc;
        r.res.pidx    = pidx[mec_pkg::PIDX_W-1:0];
        return r;
    endfunction

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t plan[$];
        int       phase;
        int       k;

        // Reset view: the center never escapes, the corners escape at once, and
        // c = -2 sits exactly on the escape circle forever.
        plan.push_back(known_row(0, 0, mec_pkg::COUNT_LIMIT_RST, 1'b0, 0));
        plan.push_back(pixel_row(-512, -512));
        plan.push_back(pixel_row(511, 511));
        plan.push_back(pixel_row(-512, 0));
        // A limit of 2 allows one iteration only.
        plan.push_back(reg_row(mec_pkg::CFG_COUNT_LIM, 2));
        plan.push_back(known_row(0, 0, 2, 1'b0, 0));
        plan.push_back(known_row(-512, 511, 2, 1'b0, 0));
        // An odd limit lets the count end one above it.
        plan.push_back(reg_row(mec_pkg::CFG_COUNT_LIM, 3));
        plan.push_back(known_row(0, 0, 4, 1'b0, 0));
        plan.push_back(reg_row(mec_pkg::CFG_CENTER_RE, 32'h7FFF_FFFF));
        plan.push_back(known_row(511, 0, 2, 1'b1, 2));
        // Saturation of c at both ends of the Q4.28 range.
        plan.push_back(reg_row(mec_pkg::CFG_COUNT_LIM, 1000));
        plan.push_back(reg_row(mec_pkg::CFG_PIXEL_STEP, 32'h7FFF_FFFF));
        plan.push_back(reg_row(mec_pkg::CFG_CENTER_RE, 32'h8000_0000));
        plan.push_back(reg_row(mec_pkg::CFG_CENTER_IM, 32'h7FFF_FFFF));
        plan.push_back(known_row(-512, 511, 2, 1'b1, 2));
        plan.push_back(known_row(511, -512, 2, 1'b1, 2));
        // A zero step maps every pixel onto the center.
        plan.push_back(reg_row(mec_pkg::CFG_CENTER_RE, 0));
        plan.push_back(reg_row(mec_pkg::CFG_CENTER_IM, 0));
        plan.push_back(reg_row(mec_pkg::CFG_PIXEL_STEP, 0));
        plan.push_back(known_row(-300, 200, 1000, 1'b0, 0));
        // A write past the last register leaves the view alone.
        plan.push_back(reg_row(mec_pkg::CFG_COUNT_LIM + 3'd2, 32'h1234_5678));
        plan.push_back(known_row(7, 7, 1000, 1'b0, 0));
        plan.push_back(reg_row(mec_pkg::CFG_COUNT_LIM, 65534));
        plan.push_back(known_row(0, 0, 65534, 1'b0, 0));
        // With the full 16-bit limit the count saturates.
        plan.push_back(reg_row(mec_pkg::CFG_COUNT_LIM, 65535));
        plan.push_back(known_row(-1, -1, 65535, 1'b0, 0));
        // Near -0.75 + 0.01i escape takes a few hundred iterations, so the index wraps.
        plan.push_back(reg_row(mec_pkg::CFG_COUNT_LIM, 1000));
        plan.push_back(reg_row(mec_pkg::CFG_PIXEL_STEP, 1));
        plan.push_back(reg_row(mec_pkg::CFG_CENTER_RE, 32'hF400_0000));
        plan.push_back(reg_row(mec_pkg::CFG_CENTER_IM, 32'h0028_F5C3));
        plan.push_back(pixel_row(0, 0));
        plan.push_back(pixel_row(-512, 511));
        plan.push_back(pixel_row(511, -512));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle(SETTLE_CYCLES);
                write_reg(plan[i].idx, plan[i].value);
            end
            else
                send_pixel(plan[i].ox, plan[i].oy, plan[i].typed, plan[i].res);
        end

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 74;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 74;
                end
                default:
                begin
                    sender_idle_pct = 30;
                    recv_stall_pct  = 30;
                end
            endcase
            settle(SETTLE_CYCLES);
            random_view();
            for (k = 0; k < 13; k++)
            begin
                if (k == 6 || $urandom_range(15) == 0)
                    settle(1);
                send_pixel($urandom_range(1023), $urandom_range(1023), 1'b0, '0);
            end
        end

        settle(END_CYCLES);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
